// ===== src/lcfd_pkg.sv =====
// Shared types and constants for the length/checksum frame deframer.
// Used by lcfd_ctrl, lcfd_datapath and length_checksum_frame_deframer_unit.
package lcfd_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;

    localparam logic REG_HEADER_CODE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_RD,
        ST_HDR_CK,
        ST_LEN_CK,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_ONE,
        RD_IDX_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic    push;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    drop_one;
        logic    drop_frame;
        logic    len_load;
        logic    idx_clr;
        logic    idx_inc;
        logic    sum_add;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt2;
        logic hdr_match;
        logic len_too_long;
        logic frame_short;
        logic idx_le_len;
        logic idx_last;
        logic sum_ok;
        logic out_free;
    } status_t;

endpackage

// ===== src/length_checksum_frame_deframer_unit.sv =====
// Length/checksum frame deframer: a byte is taken in idle, then the window is
// rescanned before the next byte: header check, length check, checksum of an L+2
// byte frame, then output of its L+2 bytes, held by output stalls; a failed check
// drops one byte. The worst case per byte is set by rescans of short failing frames
// through the single read port. Reset empties the window and clears header_code;
// window contents are not cleared.
module length_checksum_frame_deframer_unit #(
    parameter int WINDOW_DEPTH = lcfd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_first,
    output logic        frame_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lcfd_pkg::cmd_t    cmd;
    lcfd_pkg::status_t sts;

    logic [7:0] header_code_reg;
    logic [7:0] header_code_next;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lcfd_pkg::REG_HEADER_CODE);
    assign header_code_next = cfg_wr ? pwdata[7:0] : header_code_reg;
    assign prdata = (paddr[2] == lcfd_pkg::REG_HEADER_CODE) ? {24'd0, header_code_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_code_reg <= '0;
        end
        else
        begin
            header_code_reg <= header_code_next;
        end
    end

    lcfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcfd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .header_code (header_code_reg),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_first (frame_first),
        .frame_last  (frame_last)
    );

endmodule

// ===== src/lcfd_ctrl.sv =====
// Scan sequencer of the deframer: accepts a byte, then walks the window.
// Depends on lcfd_pkg; drives lcfd_datapath through cmd_t, reads status_t.
module lcfd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lcfd_pkg::status_t sts,
    output lcfd_pkg::cmd_t   cmd
);

    lcfd_pkg::state_t state_reg;
    lcfd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcfd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = lcfd_pkg::RD_HEAD;
        in_stall   = 1'b1;
        case (state_reg)
            lcfd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.push   = 1'b1;
                    state_next = lcfd_pkg::ST_HDR_RD;
                end
            end
            lcfd_pkg::ST_HDR_RD:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = lcfd_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = lcfd_pkg::RD_HEAD;
                    state_next = lcfd_pkg::ST_HDR_CK;
                end
            end
            lcfd_pkg::ST_HDR_CK:
            begin
                if (!sts.hdr_match)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = lcfd_pkg::ST_HDR_RD;
                end
                else if (sts.cnt_lt2)
                begin
                    state_next = lcfd_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = lcfd_pkg::RD_ONE;
                    state_next = lcfd_pkg::ST_LEN_CK;
                end
            end
            lcfd_pkg::ST_LEN_CK:
            begin
                if (sts.len_too_long)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = lcfd_pkg::ST_HDR_RD;
                end
                else if (sts.frame_short)
                begin
                    state_next = lcfd_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.len_load = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = lcfd_pkg::RD_HEAD;
                    state_next   = lcfd_pkg::ST_SUM;
                end
            end
            lcfd_pkg::ST_SUM:
            begin
                if (sts.idx_le_len)
                begin
                    cmd.sum_add = 1'b1;
                    cmd.idx_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = lcfd_pkg::RD_IDX_NEXT;
                end
                else if (sts.sum_ok)
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = lcfd_pkg::RD_HEAD;
                    state_next  = lcfd_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = lcfd_pkg::ST_HDR_RD;
                end
            end
            lcfd_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.drop_frame = 1'b1;
                        state_next     = lcfd_pkg::ST_HDR_RD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = lcfd_pkg::RD_IDX_NEXT;
                    end
                end
            end
            default:
            begin
                state_next = lcfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lcfd_datapath.sv =====
// Window ring buffer, scan index, running checksum and output register.
// Depends on lcfd_pkg; commanded by lcfd_ctrl.
module lcfd_datapath #(
    parameter int WINDOW_DEPTH = lcfd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lcfd_pkg::cmd_t    cmd,
    output lcfd_pkg::status_t sts,
    input  logic [7:0]        header_code,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        frame_byte,
    output logic              frame_first,
    output logic              frame_last
);

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = IW + 1;

    logic [7:0]    mem [WINDOW_DEPTH];
    logic [7:0]    rd_data_reg;

    logic [IW-1:0] head_reg;
    logic [IW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [IW-1:0] len_reg;
    logic [IW-1:0] len_next;
    logic [7:0]    sum_reg;
    logic [7:0]    sum_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    frame_byte_reg;
    logic          frame_first_reg;
    logic          frame_last_reg;

    logic [SW-1:0] frame_len;
    logic [SW-1:0] rd_off;
    logic [SW-1:0] rd_sum;
    logic [IW-1:0] rd_addr;
    logic [SW-1:0] wr_sum;
    logic [IW-1:0] wr_addr;
    logic [SW-1:0] drop_sum;
    logic [IW-1:0] head_inc;
    logic          full;
    logic          out_free;

    assign frame_len = SW'(len_reg) + SW'(2);
    assign full      = (count_reg == CW'(WINDOW_DEPTH));
    assign out_free  = !out_valid_reg || !out_stall;
    assign head_inc  = (head_reg == IW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + IW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            lcfd_pkg::RD_HEAD:     rd_off = '0;
            lcfd_pkg::RD_ONE:      rd_off = SW'(1);
            lcfd_pkg::RD_IDX_NEXT: rd_off = SW'(idx_reg) + SW'(1);
            default:               rd_off = '0;
        endcase
    end

    always_comb
    begin
        logic [SW-1:0] rs;
        logic [SW-1:0] ws;
        logic [SW-1:0] ds;
        rs = SW'(head_reg) + rd_off;
        ws = SW'(head_reg) + SW'(count_reg);
        ds = SW'(head_reg) + frame_len;
        rd_sum   = (rs >= SW'(WINDOW_DEPTH)) ? rs - SW'(WINDOW_DEPTH) : rs;
        wr_sum   = (ws >= SW'(WINDOW_DEPTH)) ? ws - SW'(WINDOW_DEPTH) : ws;
        drop_sum = (ds >= SW'(WINDOW_DEPTH)) ? ds - SW'(WINDOW_DEPTH) : ds;
    end

    assign rd_addr = rd_sum[IW-1:0];
    assign wr_addr = wr_sum[IW-1:0];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            if (full)
            begin
                head_next = head_inc;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (cmd.drop_one)
        begin
            head_next  = head_inc;
            count_next = count_reg - CW'(1);
        end
        else if (cmd.drop_frame)
        begin
            head_next  = drop_sum[IW-1:0];
            count_next = count_reg - CW'(frame_len);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        len_next = len_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        else
        begin
            if (cmd.idx_inc)
            begin
                idx_next = idx_reg + IW'(1);
            end
            if (cmd.sum_add)
            begin
                sum_next = sum_reg + rd_data_reg;
            end
        end
        if (cmd.len_load)
        begin
            len_next = rd_data_reg[IW-1:0];
        end
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.out_load)
        begin
            frame_byte_reg  <= rd_data_reg;
            frame_first_reg <= (idx_reg == '0);
            frame_last_reg  <= sts.idx_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        sts.cnt_zero     = (count_reg == '0);
        sts.cnt_lt2      = (count_reg < CW'(2));
        sts.hdr_match    = (rd_data_reg == header_code);
        sts.len_too_long = ((9'(rd_data_reg) + 9'd2) > 9'(WINDOW_DEPTH));
        sts.frame_short  = (9'(count_reg) < (9'(rd_data_reg) + 9'd2));
        sts.idx_le_len   = (idx_reg <= len_reg);
        sts.idx_last     = (SW'(idx_reg) == (SW'(len_reg) + SW'(1)));
        sts.sum_ok       = (sum_reg == rd_data_reg);
        sts.out_free     = out_free;
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = frame_byte_reg;
    assign frame_first = frame_first_reg;
    assign frame_last  = frame_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW_DEPTH))
        else $error("window count above depth");

    a_frame_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_frame |-> (SW'(count_reg) >= frame_len))
        else $error("frame consumed beyond buffered bytes");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && full) |=> (count_reg == CW'(WINDOW_DEPTH)))
        else $error("push into full window changed count");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.out_load)
        else $error("output overwritten while stalled");
`endif

endmodule
